// ===== hdl/dmn_pkg.sv =====
package dmn_pkg;

  localparam int MAX_NODES = 16;
  localparam int ID_SLOTS  = 16;
  localparam int NODE_LIMIT = (MAX_NODES < ID_SLOTS) ? MAX_NODES : ID_SLOTS;

  localparam int ID_W   = 5;
  localparam int SEQ_W  = 16;
  localparam int IDX_W  = $clog2(ID_SLOTS);
  localparam int PEND_W = 4;

  localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

  typedef enum logic [1:0] {
    OP_ASK     = 2'd0,
    OP_REQUEST = 2'd1,
    OP_REPLY   = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_GRANT   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic {
    REG_NODE_COUNT = 1'b0,
    REG_MY_ID      = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic scan;
  } dmn_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic op_scan;
    logic work_empty;
  } dmn_status_t;

endpackage

// ===== hdl/dmn_ctrl.sv =====
module dmn_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dmn_pkg::dmn_status_t status,
  output dmn_pkg::dmn_cmd_t    cmd
);
  import dmn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        // state update waits until the output slot can take a result
        if (status.slot_free) state_nxt = status.op_scan ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.work_empty) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ===== hdl/dmn_dp.sv =====
module dmn_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dmn_pkg::dmn_cmd_t                  cmd,
  output dmn_pkg::dmn_status_t               status,
  input  logic [1:0]                         in_operation,
  input  logic [dmn_pkg::ID_W-1:0]           in_peer_id,
  input  logic [dmn_pkg::SEQ_W-1:0]          in_peer_sequence,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [dmn_pkg::ID_W-1:0]           cfg_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_kind,
  output logic [dmn_pkg::ID_W-1:0]           out_destination,
  output logic [dmn_pkg::SEQ_W-1:0]          out_sequence_res,
  output logic                               out_last
);
  import dmn_pkg::*;

  localparam logic [ID_W-1:0] LIMIT = ID_W'(NODE_LIMIT);

  logic [ID_W-1:0]     node_count_r, my_id_r;
  op_t                 op_r;
  logic [ID_W-1:0]     pid_r;
  logic [SEQ_W-1:0]    pseq_r;
  logic [SEQ_W-1:0]    own_seq_r, own_seq_nxt;
  logic [SEQ_W-1:0]    high_seq_r, high_seq_nxt;
  logic [PEND_W-1:0]   pending_r, pending_nxt;
  logic                requesting_r, requesting_nxt;
  logic [ID_SLOTS-1:0] deferred_r, deferred_nxt;
  logic [ID_SLOTS-1:0] work_r, work_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  kind_t               scan_kind_r, scan_kind_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]     out_dest_r, out_dest_nxt;
  logic [SEQ_W-1:0]    out_seq_r, out_seq_nxt;
  logic                out_last_r, out_last_nxt;

  logic [ID_W-1:0]     n_eff;
  logic [ID_SLOTS-1:0] range_mask, me_mask, idx_bit;
  logic                slot_free;
  logic                ask_ok, req_ok, hold;
  logic [IDX_W-1:0]    pid_idx;
  logic [SEQ_W-1:0]    seq_inc;

  assign n_eff     = (node_count_r > LIMIT) ? LIMIT : node_count_r;
  assign slot_free = !out_valid_r || !out_stall;
  assign pid_idx   = IDX_W'(pid_r - ID_W'(1));
  assign seq_inc   = (high_seq_r == SEQ_MAX) ? high_seq_r : high_seq_r + SEQ_W'(1);

  always_comb begin
    for (int p = 0; p < ID_SLOTS; p++) begin
      range_mask[p] = ((p + 1) <= int'(n_eff));
      me_mask[p]    = ((p + 1) == int'(my_id_r));
      idx_bit[p]    = (p == int'(idx_r));
    end
  end

  assign ask_ok = !requesting_r && (n_eff >= ID_W'(2)) && (my_id_r != '0)
                  && (my_id_r <= n_eff);
  assign req_ok = (pid_r != '0) && (pid_r <= n_eff) && (pid_r != my_id_r);
  assign hold   = requesting_r && ((pseq_r > own_seq_r)
                  || ((pseq_r == own_seq_r) && (pid_r > my_id_r)));

  always_comb begin
    own_seq_nxt    = own_seq_r;
    high_seq_nxt   = high_seq_r;
    pending_nxt    = pending_r;
    requesting_nxt = requesting_r;
    deferred_nxt   = deferred_r;
    work_nxt       = work_r;
    idx_nxt        = idx_r;
    scan_kind_nxt  = scan_kind_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_dest_nxt   = out_dest_r;
    out_seq_nxt    = out_seq_r;
    out_last_nxt   = out_last_r;

    if (cmd.execute && slot_free) begin
      idx_nxt = '0;
      unique case (op_r)
        OP_ASK: begin
          if (ask_ok) begin
            requesting_nxt = 1'b1;
            high_seq_nxt   = seq_inc;
            own_seq_nxt    = seq_inc;
            pending_nxt    = PEND_W'(n_eff - ID_W'(1));
            work_nxt       = range_mask & ~me_mask;
            scan_kind_nxt  = KIND_REQUEST;
          end
        end
        OP_REQUEST: begin
          if (req_ok) begin
            if (pseq_r > high_seq_r) high_seq_nxt = pseq_r;
            if (hold) begin
              deferred_nxt[pid_idx] = 1'b1;
            end else begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_REPLY;
              out_dest_nxt  = pid_r;
              out_seq_nxt   = '0;
              out_last_nxt  = 1'b1;
            end
          end
        end
        OP_REPLY: begin
          if (pending_r != '0) begin
            pending_nxt = pending_r - PEND_W'(1);
            if ((pending_r == PEND_W'(1)) && requesting_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_GRANT;
              out_dest_nxt  = '0;
              out_seq_nxt   = '0;
              out_last_nxt  = 1'b1;
            end
          end
        end
        OP_RELEASE: begin
          requesting_nxt = 1'b0;
          pending_nxt    = '0;
          work_nxt       = deferred_r & range_mask & ~me_mask;
          deferred_nxt   = '0;
          scan_kind_nxt  = KIND_REPLY;
        end
        default: ;
      endcase
    end

    // one id position per cycle; a set position waits for the output slot
    if (cmd.scan && (work_r != '0)) begin
      if (!work_r[idx_r]) begin
        idx_nxt = idx_r + IDX_W'(1);
      end else if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = scan_kind_r;
        out_dest_nxt  = ID_W'(idx_r) + ID_W'(1);
        out_seq_nxt   = (scan_kind_r == KIND_REQUEST) ? own_seq_r : '0;
        out_last_nxt  = ((work_r & ~idx_bit) == '0);
        work_nxt      = work_r & ~idx_bit;
        idx_nxt       = idx_r + IDX_W'(1);
      end
    end
  end

  assign status.slot_free  = slot_free;
  assign status.op_scan    = (op_r == OP_ASK) || (op_r == OP_RELEASE);
  assign status.work_empty = (work_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= ID_W'(2);
      my_id_r      <= ID_W'(1);
      own_seq_r    <= '0;
      high_seq_r   <= '0;
      pending_r    <= '0;
      requesting_r <= 1'b0;
      deferred_r   <= '0;
      work_r       <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_NODE_COUNT: node_count_r <= cfg_data;
          REG_MY_ID:      my_id_r      <= cfg_data;
          default: ;
        endcase
      end
      own_seq_r    <= own_seq_nxt;
      high_seq_r   <= high_seq_nxt;
      pending_r    <= pending_nxt;
      requesting_r <= requesting_nxt;
      deferred_r   <= deferred_nxt;
      work_r       <= work_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_operation);
      pid_r  <= in_peer_id;
      pseq_r <= in_peer_sequence;
    end
    scan_kind_r <= scan_kind_nxt;
    out_kind_r  <= out_kind_nxt;
    out_dest_r  <= out_dest_nxt;
    out_seq_r   <= out_seq_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_destination  = out_dest_r;
  assign out_sequence_res = out_seq_r;
  assign out_last         = out_last_r;

endmodule

// ===== hdl/distributed_mutex_node_core.sv =====
// One node of Ricart-Agrawala mutual exclusion. Each accepted event is captured
// into registers and then executed once the output slot is free; a peer request
// or reply then leaves at most one result in the output register. Ask and
// release walk the node ids one per cycle in a scan loop, waiting at a set id
// while the output slot is held, until no id remains to be sent, then leave
// the loop. The next event is taken once the scan is done, even if the final
// result still waits in the output register. The user must write node_count
// and my_id only while idle; the block itself does not enforce it.
module distributed_mutex_node_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic [dmn_pkg::ID_W-1:0]  in_peer_id,
  input  logic [dmn_pkg::SEQ_W-1:0] in_peer_sequence,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_kind,
  output logic [dmn_pkg::ID_W-1:0]  out_destination,
  output logic [dmn_pkg::SEQ_W-1:0] out_sequence_res,
  output logic                      out_last,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [dmn_pkg::ID_W-1:0]  cfg_data
);
  import dmn_pkg::*;

  dmn_cmd_t    cmd;
  dmn_status_t status;

  dmn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dmn_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_operation     (in_operation),
    .in_peer_id       (in_peer_id),
    .in_peer_sequence (in_peer_sequence),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_destination  (out_destination),
    .out_sequence_res (out_sequence_res),
    .out_last         (out_last)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dmn_pkg::*;

  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] pid;
    logic [SEQ_W-1:0] pseq;
  } node_evt_t;

  typedef struct packed {
    kind_t            kind;
    logic [ID_W-1:0]  dest;
    logic [SEQ_W-1:0] seq;
    logic             last;
  } node_msg_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_operation = '0;
  logic [ID_W-1:0]  in_peer_id = '0;
  logic [SEQ_W-1:0] in_peer_sequence = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_kind;
  logic [ID_W-1:0]  out_destination;
  logic [SEQ_W-1:0] out_sequence_res;
  logic             out_last;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [ID_W-1:0]  cfg_data = '0;

  distributed_mutex_node_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_peer_id       (in_peer_id),
    .in_peer_sequence (in_peer_sequence),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_destination  (out_destination),
    .out_sequence_res (out_sequence_res),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // node model state
  logic [ID_W-1:0]   cfg_nodes = 5'd2;
  logic [ID_W-1:0]   cfg_me = 5'd1;
  logic [SEQ_W-1:0]  own_seq = '0;
  logic [SEQ_W-1:0]  high_seq = '0;
  logic [PEND_W-1:0] replies_left = '0;
  logic              asking = 1'b0;
  logic [ID_SLOTS:1] deferred = '0;

  node_evt_t event_q[$];
  node_msg_t expected_msgs[$];
  int        err_cnt = 0;
  int        evt_total = 0;
  int        gen_high = 0;
  bit        calm = 1'b0;
  bit        in_took = 1'b0;
  int        send_gap = 0;
  int        stall_left = 0;
  int        long_hold_req = 0;
  int        long_hold_done = 0;

  task automatic node_apply_event(input op_t op, input logic [ID_W-1:0] pid,
                                  input logic [SEQ_W-1:0] pseq);
    int        n;
    int        me;
    int        j;
    bit        hold;
    node_msg_t batch[$];
    n = (cfg_nodes > NODE_LIMIT) ? NODE_LIMIT : cfg_nodes;
    me = cfg_me;
    case (op)
      OP_ASK: begin
        if (!asking && n >= 2 && me != 0 && me <= n) begin
          asking = 1'b1;
          if (high_seq != SEQ_MAX) high_seq = high_seq + 1'b1;
          own_seq = high_seq;
          for (j = 1; j <= n; j++) begin
            if (j != me) batch.push_back('{KIND_REQUEST, ID_W'(j), own_seq, 1'b0});
          end
          replies_left = PEND_W'(batch.size());
        end
      end
      OP_REQUEST: begin
        if (pid != 0 && pid <= n && pid != me) begin
          if (pseq > high_seq) high_seq = pseq;
          // defer when our own request wins on (sequence, id)
          hold = asking && (pseq > own_seq || (pseq == own_seq && pid > me));
          if (hold) deferred[pid] = 1'b1;
          else batch.push_back('{KIND_REPLY, pid, SEQ_W'(0), 1'b0});
        end
      end
      OP_REPLY: begin
        if (replies_left != 0) begin
          replies_left = replies_left - 1'b1;
          if (replies_left == 0 && asking)
            batch.push_back('{KIND_GRANT, ID_W'(0), SEQ_W'(0), 1'b0});
        end
      end
      OP_RELEASE: begin
        asking = 1'b0;
        replies_left = '0;
        for (j = 1; j <= n; j++) begin
          if (deferred[j] && j != me)
            batch.push_back('{KIND_REPLY, ID_W'(j), SEQ_W'(0), 1'b0});
        end
        deferred = '0;
      end
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) expected_msgs.push_back(batch[k]);
  endtask

  // input side: new payload only after a transfer or while idle
  always @(negedge clk) begin : drive
    node_evt_t e;
    logic      nv;
    nv = in_valid;
    if (!in_valid || in_took) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (rst_n && event_q.size() > 0) begin
        e = event_q.pop_front();
        nv = 1'b1;
        in_operation <= e.op;
        in_peer_id <= e.pid;
        in_peer_sequence <= e.pseq;
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
      end
    end
    in_valid <= nv;
  end

  // result side stall bursts and the long hold-off
  always @(negedge clk) begin : hold_off
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (long_hold_req != long_hold_done) begin
      long_hold_done++;
      stall_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : watch
    node_msg_t m;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_msgs.size() == 0) begin
          $error("unexpected result: kind %0d destination %0d sequence_res %0d last %0d",
                 out_kind, out_destination, out_sequence_res, out_last);
          err_cnt++;
        end else begin
          m = expected_msgs.pop_front();
          if (out_kind !== m.kind) begin
            $error("kind: expected %0d, actual %0d", m.kind, out_kind);
            err_cnt++;
          end
          if (out_destination !== m.dest) begin
            $error("destination: expected %0d, actual %0d", m.dest, out_destination);
            err_cnt++;
          end
          if (out_sequence_res !== m.seq) begin
            $error("sequence_res: expected %0d, actual %0d", m.seq, out_sequence_res);
            err_cnt++;
          end
          if (out_last !== m.last) begin
            $error("last: expected %0d, actual %0d", m.last, out_last);
            err_cnt++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_NODE_COUNT) cfg_nodes = cfg_data;
        else cfg_me = cfg_data;
      end
      if (in_valid && !in_stall)
        node_apply_event(op_t'(in_operation), in_peer_id, in_peer_sequence);
    end
  end

  task automatic add_evt(input op_t op, input int pid, input int pseq);
    node_evt_t e;
    e.op = op;
    e.pid = pid[ID_W-1:0];
    e.pseq = pseq[SEQ_W-1:0];
    event_q.push_back(e);
    evt_total++;
  endtask

  function automatic int near_seq();
    int v;
    v = gen_high + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 65534) v = 65534;
    return v;
  endfunction

  function automatic int pick_peer(input int n, input int me);
    int p;
    do p = $urandom_range(1, n); while (p == me);
    return p;
  endfunction

  task automatic peer_request(input int n, input int me);
    int s;
    s = near_seq();
    if (s > gen_high) gen_high = s;
    add_evt(OP_REQUEST, pick_peer(n, me), s);
  endtask

  task automatic add_noise();
    op_t op;
    int  s;
    op = op_t'($urandom_range(0, 3));
    s = $urandom_range(0, 65535);
    if (op == OP_REQUEST) begin
      s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65534) : near_seq();
      if (s > gen_high) gen_high = s;
    end
    add_evt(op, $urandom_range(0, 31), s);
  endtask

  // ask, replies mixed with peer requests and noise, then release
  task automatic mutex_round(input int n, input int me);
    int owed;
    add_evt(OP_ASK, $urandom_range(0, 31), $urandom_range(0, 65535));
    if (gen_high < 65534) gen_high++;
    owed = n - 1;
    while (owed > 0) begin
      case (int'($urandom_range(0, 19))) inside
        [0:10]: begin
          add_evt(OP_REPLY, pick_peer(n, me), $urandom_range(0, 65535));
          owed--;
        end
        [11:16]: peer_request(n, me);
        [17:18]: add_noise();
        default: owed = 0;  // give up before the grant
      endcase
    end
    repeat ($urandom_range(0, 2)) peer_request(n, me);
    add_evt(OP_RELEASE, $urandom_range(0, 31), $urandom_range(0, 65535));
  endtask

  task automatic settle();
    do @(posedge clk); while (event_q.size() != 0 || in_valid || expected_msgs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [ID_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [ID_W-1:0] nc, input logic [ID_W-1:0] me,
                           input int budget, input bit squeeze);
    int n;
    int stop;
    settle();
    write_reg(REG_NODE_COUNT, nc);
    write_reg(REG_MY_ID, me);
    if (squeeze) long_hold_req++;
    n = (nc > NODE_LIMIT) ? NODE_LIMIT : nc;
    stop = evt_total + budget;
    while (evt_total < stop) begin
      if (n < 2 || $urandom_range(0, 4) == 0) add_noise();
      else mutex_round(n, me);
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_NODE_COUNT, 5'd4);
    write_reg(REG_MY_ID, 5'd2);
    add_evt(OP_RELEASE, 1, 0);        // nothing deferred
    add_evt(OP_REPLY, 1, 0);          // nothing outstanding
    add_evt(OP_REQUEST, 0, 5);        // bad senders
    add_evt(OP_REQUEST, 2, 5);
    add_evt(OP_REQUEST, 5, 5);
    add_evt(OP_REQUEST, 31, 16'hFFFF);
    add_evt(OP_REQUEST, 1, 0);
    add_evt(OP_REQUEST, 4, 9);
    add_evt(OP_ASK, 0, 16'hFFFF);
    add_evt(OP_ASK, 31, 0);           // already asking
    add_evt(OP_REQUEST, 3, 10);       // tie, higher id waits
    add_evt(OP_REQUEST, 1, 10);       // tie, lower id wins
    add_evt(OP_REQUEST, 4, 11);
    add_evt(OP_REQUEST, 4, 4);
    add_evt(OP_REPLY, 1, 0);
    add_evt(OP_REPLY, 3, 0);
    add_evt(OP_REPLY, 4, 0);
    add_evt(OP_REPLY, 4, 0);
    add_evt(OP_RELEASE, 0, 0);
    add_evt(OP_ASK, 0, 0);
    add_evt(OP_REPLY, 1, 0);
    add_evt(OP_RELEASE, 0, 0);        // abandon before the grant
    add_evt(OP_REPLY, 3, 0);
    gen_high = 12;

    run_phase(5'd16, 5'd16, 40, 1'b1);
    run_phase(5'd2, 5'd1, 20, 1'b0);
    run_phase(5'd5, 5'd3, 30, 1'b0);
    run_phase(5'd31, 5'd7, 15, 1'b0);
    run_phase(5'd31, 5'd7, 15, 1'b0);
    run_phase(5'd8, 5'd0, 10, 1'b0);
    run_phase(5'd3, 5'd9, 10, 1'b0);
    run_phase(5'd1, 5'd1, 8, 1'b0);
    run_phase(5'd0, 5'd31, 8, 1'b0);

    calm = 1'b1;
    run_phase(5'd16, 5'd1, 30, 1'b0);
    // sequence saturation at the top of the range
    add_evt(OP_REQUEST, 2, 16'hFFFF);
    add_evt(OP_ASK, 0, 0);
    add_evt(OP_REQUEST, 3, 16'hFFFF);
    add_evt(OP_ASK, 0, 0);
    for (k = 2; k <= 16; k++) add_evt(OP_REPLY, k, 0);
    add_evt(OP_RELEASE, 0, 0);
    add_evt(OP_ASK, 0, 0);
    add_evt(OP_RELEASE, 0, 0);

    settle();
    if (err_cnt == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
